FILE: rtl/vfct_pkg.sv
// Shared types and constants of the view frustum culling tester.
package vfct_pkg;

  // query commands
  localparam logic [2:0] CMD_POINT_IN  = 3'd0;
  localparam logic [2:0] CMD_SPHERE_X  = 3'd1;
  localparam logic [2:0] CMD_BOX_X     = 3'd2;
  localparam logic [2:0] CMD_SPHERE_IN = 3'd3;
  localparam logic [2:0] CMD_BOX_IN    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_ROW0 = 3'd0;
  localparam logic [2:0] CFG_ROW1 = 3'd1;
  localparam logic [2:0] CFG_ROW2 = 3'd2;
  localparam logic [2:0] CFG_ROW3 = 3'd3;
  localparam logic [2:0] CFG_DTOL = 3'd4;

  localparam int NUM_PLANES = 6;
  localparam int NUM_COEFS  = 24;

  // one plane coefficient write from the plane generator
  typedef struct packed {
    logic               we;
    logic [4:0]         idx;
    logic signed [31:0] data;
  } coef_wr_t;

endpackage

FILE: rtl/vfct_plane_gen.sv
// Plane extraction and normalization sequencer (isqrt and divider, bit serial).
module vfct_plane_gen #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [3:0][63:0]      rows,
  output logic                  busy,
  output vfct_pkg::coef_wr_t    wr
);
  import vfct_pkg::*;

  localparam int DW = (COORD_FRAC_BITS + 31 > 45) ? COORD_FRAC_BITS + 31 : 45;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ROOT  = 6'b000100,
    ST_COMP  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_WRITE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] plane_r, plane_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic signed [16:0] raw_r [4];
  logic signed [16:0] raw_nxt [4];
  logic        zero_r, zero_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] op_r, op_nxt, res_r, res_nxt, one_r, one_nxt;
  logic [30:0] root_r, root_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;

  // datapath temporaries
  logic signed [16:0] ent3, ents;
  logic signed [33:0] sq [3];
  logic [35:0] ssum;
  logic [63:0] rt;
  logic [16:0] mag;
  logic [DW-1:0] num;
  logic [31:0] rem_t;
  logic [DW-1:0] lim;
  logic [31:0] lim_val, qval;
  logic signed [39:0] ez;
  logic [31:0] wval;

  always_comb begin
    state_nxt = state_r;
    plane_nxt = plane_r;
    comp_nxt  = comp_r;
    cnt_nxt   = cnt_r;
    raw_nxt   = raw_r;
    zero_nxt  = zero_r;
    neg_nxt   = neg_r;
    op_nxt    = op_r;
    res_nxt   = res_r;
    one_nxt   = one_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    ssum      = '0;
    rt        = res_r + one_r;
    mag       = '0;
    num       = '0;
    rem_t     = {rem_r[30:0], quo_r[DW-1]};
    ent3      = '0;
    ents      = '0;
    for (int k = 0; k < 3; k++) sq[k] = '0;

    // saturation of the result word
    lim     = neg_r ? ((comp_r == 2'd3) ? DW'(64'h8000_0000) : DW'(64'h8000))
                    : ((comp_r == 2'd3) ? DW'(64'h7FFF_FFFF) : DW'(64'h7FFF));
    lim_val = neg_r ? ((comp_r == 2'd3) ? 32'h8000_0000 : 32'hFFFF_8000)
                    : ((comp_r == 2'd3) ? 32'h7FFF_FFFF : 32'h0000_7FFF);
    qval    = neg_r ? 32'd0 - quo_r[31:0] : quo_r[31:0];
    ez      = 40'(raw_r[3]) <<< (COORD_FRAC_BITS - 8);
    if (zero_r) begin
      if (comp_r != 2'd3) wval = '0;
      else if (ez > 40'sh00_7FFF_FFFF) wval = 32'h7FFF_FFFF;
      else if (ez < 40'shFF_8000_0000) wval = 32'h8000_0000;
      else wval = ez[31:0];
    end else begin
      wval = (quo_r > lim) ? lim_val : qval;
    end

    unique case (state_r)
      ST_IDLE: ;
      ST_LOAD: begin
        for (int k = 0; k < 4; k++) begin
          ent3 = $signed(rows[3][16*k +: 16]);
          ents = $signed(rows[plane_r[2:1]][16*k +: 16]);
          raw_nxt[k] = plane_r[0] ? ent3 - ents : ent3 + ents;
        end
        for (int k = 0; k < 3; k++) begin
          sq[k] = 34'(raw_nxt[k]) * 34'(raw_nxt[k]);
          ssum  = ssum + 36'(sq[k][33:0]);
        end
        op_nxt   = 64'(ssum) << 28;
        res_nxt  = '0;
        one_nxt  = 64'd1 << 60;
        zero_nxt = (ssum == '0);
        comp_nxt = '0;
        state_nxt = (ssum == '0) ? ST_COMP : ST_ROOT;
      end
      ST_ROOT: begin
        if (op_r >= rt) begin
          op_nxt  = op_r - rt;
          res_nxt = (res_r >> 1) + one_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        one_nxt = one_r >> 2;
        if (one_r[0]) begin
          root_nxt  = res_nxt[30:0];
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        mag = raw_r[comp_r][16] ? 17'd0 - raw_r[comp_r] : raw_r[comp_r];
        if (comp_r == 2'd3) num = DW'(mag) << (COORD_FRAC_BITS + 14);
        else num = DW'(mag) << 28;
        quo_nxt = num + DW'(root_r >> 1);
        neg_nxt = raw_r[comp_r][16];
        rem_nxt = '0;
        cnt_nxt = CW'(DW);
        state_nxt = zero_r ? ST_WRITE : ST_DIV;
      end
      ST_DIV: begin
        if (rem_t >= {1'b0, root_r}) begin
          rem_nxt = rem_t - {1'b0, root_r};
          quo_nxt = {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_t;
          quo_nxt = {quo_r[DW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        comp_nxt = comp_r + 1'b1;
        if (comp_r == 2'd3) begin
          plane_nxt = plane_r + 1'b1;
          state_nxt = (plane_r == 3'(NUM_PLANES - 1)) ? ST_IDLE : ST_LOAD;
        end else begin
          state_nxt = ST_COMP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (start) begin
      state_nxt = ST_LOAD;
      plane_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      plane_r <= '0;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      plane_r <= plane_nxt;
      comp_r  <= comp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    raw_r  <= raw_nxt;
    zero_r <= zero_nxt;
    neg_r  <= neg_nxt;
    op_r   <= op_nxt;
    res_r  <= res_nxt;
    one_r  <= one_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign busy     = (state_r != ST_IDLE);
  assign wr.we    = (state_r == ST_WRITE);
  assign wr.idx   = {plane_r, comp_r};
  assign wr.data  = wval;

endmodule

FILE: rtl/view_frustum_culling_tester.sv
// Top level of the view frustum culling tester: config, planes, query pipeline.
// Input transfer passes stages 1 to 3 and the output register before the result
//   shows on out_valid; throughput one query per cycle while in_stall is low, set
//   by the 36 parallel normal-by-coordinate multipliers. Plane derivation runs
//   after reset and after each matrix row write; in_stall stays high meanwhile
//   (one bit-serial isqrt and divider).
// Reset (rst_n low, synchronous): identity matrix, tolerance 0, pipeline empty.
module view_frustum_culling_tester #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_ax,
  input  logic signed [31:0] in_ay,
  input  logic signed [31:0] in_az,
  input  logic signed [31:0] in_bx,
  input  logic signed [31:0] in_by_coord,
  input  logic signed [31:0] in_bz,
  input  logic [30:0]        in_radius,
  input  logic [30:0]        in_tolerance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit
);
  import vfct_pkg::*;

  // configuration registers
  logic [3:0][63:0] row_r;
  logic [30:0]      dtol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= {64'h0100_0000_0000_0000, 64'h0000_0100_0000_0000,
                 64'h0000_0000_0100_0000, 64'h0000_0000_0000_0100};
      dtol_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ROW0: row_r[0] <= cfg_wdata;
        CFG_ROW1: row_r[1] <= cfg_wdata;
        CFG_ROW2: row_r[2] <= cfg_wdata;
        CFG_ROW3: row_r[3] <= cfg_wdata;
        CFG_DTOL: dtol_r   <= cfg_wdata[30:0];
        default: ;  // beyond the register list: dropped
      endcase
    end
  end

  // plane generator, restarted by any matrix row write
  logic     gen_busy;
  coef_wr_t coef_wr;
  logic     gen_start;
  assign gen_start = cfg_we && (cfg_idx < CFG_DTOL);

  vfct_plane_gen #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_plane_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gen_start),
    .rows  (row_r),
    .busy  (gen_busy),
    .wr    (coef_wr)
  );

  // plane coefficients: nx, ny, nz (Q2.14), d per plane; kept stable by the user while queries run; unenforced
  logic signed [31:0] coef_r [NUM_COEFS];
  always_ff @(posedge clk) begin
    if (coef_wr.we) coef_r[coef_wr.idx] <= coef_wr.data;
  end

  // stage enables: a stage loads when it is empty or its content moves on
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic en1, en2, en3, en_o, in_xfer;
  assign en_o    = !out_valid_r || !out_stall;
  assign en3     = !s3_v_r || en_o;
  assign en2     = !s2_v_r || en3;
  assign en1     = !s1_v_r || en2;
  assign in_stall = gen_busy || !en1;
  assign in_xfer = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)  s1_v_r      <= in_xfer;
      if (en2)  s2_v_r      <= s1_v_r;
      if (en3)  s3_v_r      <= s2_v_r;
      if (en_o) out_valid_r <= s3_v_r;
    end
  end

  // stage 1: products n_k * a_k and n_k * b_k per plane, pass threshold
  logic signed [31:0] in_a [3];
  logic signed [31:0] in_b [3];
  logic signed [49:0] thr_in;
  logic signed [47:0] s1_pa_r [NUM_PLANES][3];
  logic signed [47:0] s1_pb_r [NUM_PLANES][3];
  logic signed [49:0] s1_thr_r;
  logic [2:0]         s1_cmd_r;

  assign in_a = '{in_ax, in_ay, in_az};
  assign in_b = '{in_bx, in_by_coord, in_bz};

  always_comb begin
    case (in_cmd)
      CMD_POINT_IN:  thr_in = -$signed({5'd0, in_tolerance, 14'd0});
      CMD_SPHERE_X:  thr_in = -$signed({5'd0, in_radius, 14'd0});
      CMD_SPHERE_IN: thr_in =  $signed({5'd0, in_radius, 14'd0});
      CMD_BOX_IN:    thr_in = -$signed({5'd0, dtol_r, 14'd0});
      default:       thr_in = '0;  // box intersect; unknown codes rejected later
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < 3; k++) begin
          s1_pa_r[p][k] <= 48'($signed(coef_r[4*p+k][15:0])) * 48'(in_a[k]);
          s1_pb_r[p][k] <= 48'($signed(coef_r[4*p+k][15:0])) * 48'(in_b[k]);
        end
      end
      s1_thr_r <= thr_in;
      s1_cmd_r <= in_cmd;
    end
  end

  // stage 2: x+y partial sums for the four xy corners, z+d for both z choices
  logic signed [49:0] s2_xy_r [NUM_PLANES][4];
  logic signed [49:0] s2_zd_r [NUM_PLANES][2];
  logic signed [49:0] s2_thr_r;
  logic [2:0]         s2_cmd_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int c = 0; c < 4; c++) begin
          s2_xy_r[p][c] <= 50'(c[0] ? s1_pb_r[p][0] : s1_pa_r[p][0])
                         + 50'(c[1] ? s1_pb_r[p][1] : s1_pa_r[p][1]);
        end
        s2_zd_r[p][0] <= 50'(s1_pa_r[p][2]) + (50'(coef_r[4*p+3]) <<< 14);
        s2_zd_r[p][1] <= 50'(s1_pb_r[p][2]) + (50'(coef_r[4*p+3]) <<< 14);
      end
      s2_thr_r <= s1_thr_r;
      s2_cmd_r <= s1_cmd_r;
    end
  end

  // stage 3: distance of each of the 8 corners to each plane against threshold
  logic [7:0] s3_pass_r [NUM_PLANES];
  logic [2:0] s3_cmd_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int c = 0; c < 8; c++) begin
          s3_pass_r[p][c] <= (s2_xy_r[p][c % 4] + s2_zd_r[p][c / 4]) >= s2_thr_r;
        end
      end
      s3_cmd_r <= s2_cmd_r;
    end
  end

  // stage 4: fold the per-plane results by command
  logic       hit_nxt;
  logic       out_hit_r;
  logic [2:0] pvx;

  always_comb begin
    hit_nxt = 1'b1;
    pvx     = '0;
    case (s3_cmd_r) inside
      CMD_POINT_IN, CMD_SPHERE_X, CMD_SPHERE_IN: begin
        for (int p = 0; p < NUM_PLANES; p++) hit_nxt = hit_nxt & s3_pass_r[p][0];
      end
      CMD_BOX_X: begin
        // p-vertex: max coordinate where the normal component is not negative
        for (int p = 0; p < NUM_PLANES; p++) begin
          pvx = {~coef_r[4*p+2][31], ~coef_r[4*p+1][31], ~coef_r[4*p][31]};
          hit_nxt = hit_nxt & s3_pass_r[p][pvx];
        end
      end
      CMD_BOX_IN: begin
        for (int p = 0; p < NUM_PLANES; p++) hit_nxt = hit_nxt & (&s3_pass_r[p]);
      end
      default: hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_o) out_hit_r <= hit_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // plane coefficients must never change under a query in flight: the user's duty, the block leaves it unenforced
  a_coef_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    coef_wr.we |-> !(s1_v_r || s2_v_r || s3_v_r || out_valid_r))
    else $error("plane coefficient written with queries in flight");

  // a result appears only out of the last pipeline stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_v_r))
    else $error("result without an item in the last stage");

  // planes are derived before the first transfer after reset
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken before plane derivation");

endmodule
